>>> rtl/fifo_handoff_mutex_unit_defines.svh
// Assertion macros shared by the lock unit modules.
// Each macro expects a signal clk, and FHM_ASSERT also rst_n, in the scope where it is used.
`ifndef FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH
`define FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH

`ifndef SYNTH

// Check a property while out of reset
`define FHM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fhm assertion failed");

// Check a property on every clock edge, reset included
`define FHM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("fhm assertion failed");

`else

`define FHM_ASSERT(label, prop)
`define FHM_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/fhm_pkg.sv
`timescale 1ns / 1ps

package fhm_pkg;

  // Number of wait queue slots
  localparam int MAX_PROCS = 16;
  localparam int QW        = $clog2(MAX_PROCS);
  localparam int CW        = $clog2(MAX_PROCS + 1);
  localparam int PID_W     = 4;

  // Request codes
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_FREED   = 3'd2,
    ST_HANDOFF = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } fhm_cmd_t;

endpackage

>>> rtl/fhm_ram.sv
`timescale 1ns / 1ps

module fhm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fhm_ctrl.sv
`timescale 1ns / 1ps
`include "fifo_handoff_mutex_unit_defines.svh"

module fhm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output fhm_pkg::fhm_cmd_t cmd
);
  import fhm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // Issue commands to the datapath
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.execute = (state_r == S_EXEC);
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;

  // Advance state, strobe the result in the cycle after execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FHM_ASSERT(a_capture_to_exec, cmd.capture |=> state_r == S_EXEC)
  `FHM_ASSERT(a_exec_strobes, state_r == S_EXEC |=> out_valid_r)
  `FHM_ASSERT(a_strobe_when_idle, out_valid_r |-> state_r == S_IDLE)

endmodule

>>> rtl/fhm_datapath.sv
`timescale 1ns / 1ps
`include "fifo_handoff_mutex_unit_defines.svh"

module fhm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fhm_pkg::fhm_cmd_t              cmd,
  input  logic                           in_cmd,
  input  logic [fhm_pkg::PID_W-1:0]      in_proc_id,
  output logic [2:0]                     out_status,
  output logic [fhm_pkg::PID_W-1:0]      out_wake_id,
  output logic [fhm_pkg::PID_W-1:0]      out_owner_id,
  output logic                           out_is_locked
);
  import fhm_pkg::*;

  // Captured request
  logic             req_cmd_r;
  logic [PID_W-1:0] req_pid_r;

  // Mutex and queue state
  logic             held_r,  held_nxt;
  logic [PID_W-1:0] owner_r, owner_nxt;
  logic [QW-1:0]    head_r,  head_nxt;
  logic [QW-1:0]    tail_r,  tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Result registers
  status_t          status_r, status_nxt;
  logic [PID_W-1:0] wake_r,   wake_nxt;
  logic [PID_W-1:0] res_owner_r;
  logic             res_locked_r;

  // Queue storage
  logic             q_we;
  logic [PID_W-1:0] q_rdata;

  fhm_ram #(
    .WIDTH (PID_W),
    .DEPTH (MAX_PROCS)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (req_pid_r),
    .re    (cmd.capture),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  // Decide the request outcome
  always_comb begin
    held_nxt   = held_r;
    owner_nxt  = owner_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wake_nxt   = '0;
    q_we       = 1'b0;
    status_nxt = ST_FREED;
    if (req_cmd_r == CMD_LOCK) begin
      priority if (!held_r) begin
        held_nxt   = 1'b1;
        owner_nxt  = req_pid_r;
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
        status_nxt = ST_GRANTED;
      end else if (count_r == CW'(MAX_PROCS)) begin
        status_nxt = ST_FULL;
      end else begin
        q_we       = cmd.execute;
        tail_nxt   = (tail_r == QW'(MAX_PROCS - 1)) ? '0 : tail_r + 1'b1;
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_BLOCKED;
      end
    end else begin
      if (count_r == '0) begin
        held_nxt   = 1'b0;
        owner_nxt  = '0;
        status_nxt = ST_FREED;
      end else begin
        wake_nxt   = q_rdata;
        head_nxt   = (head_r == QW'(MAX_PROCS - 1)) ? '0 : head_r + 1'b1;
        count_nxt  = count_r - 1'b1;
        held_nxt   = 1'b1;
        owner_nxt  = q_rdata;
        status_nxt = ST_HANDOFF;
      end
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd_r <= in_cmd;
      req_pid_r <= in_proc_id;
    end
  end

  // Update mutex state on execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      owner_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.execute) begin
      held_r  <= held_nxt;
      owner_r <= owner_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r     <= status_nxt;
      wake_r       <= wake_nxt;
      res_owner_r  <= owner_nxt;
      res_locked_r <= held_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_wake_id   = wake_r;
  assign out_owner_id  = res_owner_r;
  assign out_is_locked = res_locked_r;

  `FHM_ASSERT(a_count_bound, count_r <= CW'(MAX_PROCS))
  `FHM_ASSERT(a_free_means_empty, !held_r |-> count_r == '0)
  `FHM_ASSERT(a_empty_ptrs_meet, count_r == '0 |-> head_r == tail_r)

endmodule

>>> rtl/fifo_handoff_mutex_unit.sv
`timescale 1ns / 1ps
// Hardware mutex with first-in first-out hand-off to waiting processes.
// Input channel: drive in_cmd (lock or unlock) and in_proc_id with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Result channel: out_valid strobes for exactly one cycle with out_status,
// out_wake_id, out_owner_id and out_is_locked; the receiver must take it then.
// A taken request is executed in the S_EXEC state; its result is registered at
// the end of that state and is on the result ports during the following cycle.
// busy is high in the S_EXEC state after acceptance while the registered
// read of the wait queue memory completes, so no new request is taken then.
// A new request may be taken at the same edge that takes the previous result.
// Lock on a free mutex grants it; lock on a held mutex queues the requester
// (or reports queue full); unlock frees the mutex or hands it to the oldest
// waiter, whose id appears on out_wake_id.
// Reset (rst_n low, synchronous): mutex free, owner zero, queue empty. The
// queue storage is not cleared; only entries written by a queued lock are read.
module fifo_handoff_mutex_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic [fhm_pkg::PID_W-1:0] in_proc_id,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [fhm_pkg::PID_W-1:0] out_wake_id,
  output logic [fhm_pkg::PID_W-1:0] out_owner_id,
  output logic                      out_is_locked
);
  import fhm_pkg::*;

  fhm_cmd_t cmd;

  // Sequence each request
  fhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Mutex state, wait queue and result registers
  fhm_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_cmd        (in_cmd),
    .in_proc_id    (in_proc_id),
    .out_status    (out_status),
    .out_wake_id   (out_wake_id),
    .out_owner_id  (out_owner_id),
    .out_is_locked (out_is_locked)
  );

endmodule

>>> verif/fifo_handoff_mutex_unit_tb.sv
`timescale 1ns / 1ps

module fifo_handoff_mutex_unit_tb;
  import fhm_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_FROM   = 720;
  localparam int STALL_LIMIT  = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int SHOWN_ERRORS = 10;

  // One answer of the lock unit
  typedef struct packed {
    status_t           status;
    logic [PID_W-1:0]  wake_id;
    logic [PID_W-1:0]  owner_id;
    logic              is_locked;
  } lock_answer_t;

  // Track the mutex and the waiters, and check each answer against it
  class mutex_tracker;
    logic             held;
    logic [PID_W-1:0] owner;
    logic [PID_W-1:0] waiters [MAX_PROCS];
    int               head;
    int               tail;
    int               waiting;
    lock_answer_t     answers_due [$];
    int               errors;

    function new();
      held    = 1'b0;
      owner   = '0;
      head    = 0;
      tail    = 0;
      waiting = 0;
      errors  = 0;
      foreach (waiters[i]) waiters[i] = '0;
    endfunction

    function int advance_slot(int p);
      return (p + 1 >= MAX_PROCS) ? 0 : p + 1;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // Apply one request and queue the answer it must produce
    function void note_request(logic cmd, logic [PID_W-1:0] pid);
      lock_answer_t ans;
      ans.wake_id = '0;
      if (cmd == CMD_LOCK) begin
        if (!held) begin
          held    = 1'b1;
          owner   = pid;
          head    = 0;
          tail    = 0;
          waiting = 0;
          ans.status = ST_GRANTED;
        end else if (waiting >= MAX_PROCS) begin
          ans.status = ST_FULL;
        end else begin
          waiters[tail] = pid;
          tail          = advance_slot(tail);
          waiting++;
          ans.status = ST_BLOCKED;
        end
      end else begin
        if (waiting == 0) begin
          held  = 1'b0;
          owner = '0;
          ans.status = ST_FREED;
        end else begin
          ans.wake_id = waiters[head];
          head        = advance_slot(head);
          waiting--;
          held  = 1'b1;
          owner = ans.wake_id;
          ans.status = ST_HANDOFF;
        end
      end
      ans.owner_id  = held ? owner : '0;
      ans.is_locked = held;
      answers_due.push_back(ans);
    endfunction

    function void flag_error(string what);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("%s", what);
    endfunction

    // Compare one answer with the oldest one owed
    function void check_result(logic [2:0] status, logic [PID_W-1:0] wake_id,
                               logic [PID_W-1:0] owner_id, logic is_locked);
      lock_answer_t exp_ans;
      if (answers_due.size() == 0) begin
        flag_error($sformatf("unexpected answer: status %0d wake %0d owner %0d locked %0d",
                             status, wake_id, owner_id, is_locked));
        return;
      end
      exp_ans = answers_due.pop_front();
      if (status !== exp_ans.status)
        flag_error($sformatf("status: expected %0d, got %0d", exp_ans.status, status));
      if (wake_id !== exp_ans.wake_id)
        flag_error($sformatf("wake_id: expected %0d, got %0d", exp_ans.wake_id, wake_id));
      if (owner_id !== exp_ans.owner_id)
        flag_error($sformatf("owner_id: expected %0d, got %0d", exp_ans.owner_id, owner_id));
      if (is_locked !== exp_ans.is_locked)
        flag_error($sformatf("is_locked: expected %0d, got %0d",
                             exp_ans.is_locked, is_locked));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_cmd = CMD_LOCK;
  logic [PID_W-1:0] in_proc_id = '0;
  logic             out_valid;
  logic [2:0]       out_status;
  logic [PID_W-1:0] out_wake_id;
  logic [PID_W-1:0] out_owner_id;
  logic             out_is_locked;

  mutex_tracker sb = new();
  int           stall_cycles = 0;

  fifo_handoff_mutex_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_proc_id    (in_proc_id),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_wake_id   (out_wake_id),
    .out_owner_id  (out_owner_id),
    .out_is_locked (out_is_locked)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Take answers and requests at the edge, and watch for a stuck run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_status, out_wake_id, out_owner_id, out_is_locked);
      if (start && !busy)
        sb.note_request(in_cmd, in_proc_id);
      if (out_valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("fifo_handoff_mutex_unit_tb: errors");
          $finish;
        end
      end
    end
  end

  // Present one request and hold it until the unit takes it
  task automatic issue_request(input logic cmd, input logic [PID_W-1:0] pid);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_proc_id <= pid;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a few cycles
  task automatic pause_requests(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int sent;
    int seg_len;
    int lock_pct;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unlock of a free mutex, grant, fill the queue to full
    issue_request(CMD_UNLOCK, 4'd15);
    issue_request(CMD_LOCK, 4'd0);
    issue_request(CMD_LOCK, 4'd0);
    issue_request(CMD_LOCK, 4'd15);
    pause_requests(3);
    for (int i = 0; i < MAX_PROCS - 2; i++)
      issue_request(CMD_LOCK, PID_W'(i + 1));
    issue_request(CMD_LOCK, 4'd9);
    // Unlock by a non-owner hands off to the oldest waiter
    issue_request(CMD_UNLOCK, 4'd15);
    issue_request(CMD_LOCK, 4'd10);
    issue_request(CMD_UNLOCK, 4'd7);
    pause_requests(1);
    issue_request(CMD_UNLOCK, 4'd0);

    // Random: segments that lean toward lock, toward unlock or to neither
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 3))
        0:       lock_pct = 15;
        1:       lock_pct = 50;
        2:       lock_pct = 80;
        default: lock_pct = 97;
      endcase
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        issue_request(($urandom_range(0, 99) < lock_pct) ? CMD_LOCK : CMD_UNLOCK,
                      PID_W'($urandom_range(0, 15)));
        sent++;
        if (sent < QUIET_FROM && $urandom_range(0, 3) == 0)
          pause_requests($urandom_range(1, 9));
      end
    end
    start <= 1'b0;

    // Drain the outstanding answers, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("fifo_handoff_mutex_unit_tb: clean");
    else
      $display("fifo_handoff_mutex_unit_tb: errors");
    $finish;
  end

endmodule
